// ----- hw/rtl/integer_to_ascii_digits_defines.svh -----
// assertion macros for the integer to ascii digits block
// sampled on clk_i, disabled while rst_ni is low; needs nothing else
`ifndef INTEGER_TO_ASCII_DIGITS_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(name, ante, cons, msg)

`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/itad_pkg.sv -----
// types and constants shared by the integer to ascii digits block
// no dependencies
package itad_pkg;

  localparam int IN_NUMBER_W = 64;
  localparam int PC_W        = 3;

  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] LETTER_GAP   = 7'd7;
  localparam logic [6:0] LOWER_OFFSET = 7'h20;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  // datapath operations issued by the control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CLEAR,
    OP_DABBLE,
    OP_PLOAD,
    OP_SKIP,
    OP_EMIT
  } itad_op_e;

  // jump conditions, the jump is taken when the condition is true
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_POW2,
    C_CNT_MORE,
    C_LEAD_ZERO,
    C_EMIT_MORE
  } itad_cond_e;

  typedef struct packed {
    itad_op_e          op;
    itad_cond_e        cond;
    logic [PC_W-1:0]   target;
  } itad_uword_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_pow2;
    logic cnt_more;
    logic lead_zero;
    logic emit_more;
  } itad_cond_t;

  typedef struct packed {
    logic [IN_NUMBER_W-1:0] number;
    logic [1:0]             radix_select;
    logic                   upper_case;
  } itad_in_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last_char;
  } itad_out_t;

endpackage

// ----- hw/rtl/itad_seq.sv -----
// microcode sequencer: step counter, control store and jump logic
// depends on itad_pkg
module itad_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itad_pkg::itad_cond_t cond_i,
  output itad_pkg::itad_op_e   op_o
);
  import itad_pkg::*;

  // the shift loop falls through into the leading zero scan, so the bit
  // group load sits after the done step and jumps back to the scan
  localparam logic [PC_W-1:0] StepIdle   = 3'd0;
  localparam logic [PC_W-1:0] StepClear  = 3'd1;
  localparam logic [PC_W-1:0] StepDabble = 3'd2;
  localparam logic [PC_W-1:0] StepSkip   = 3'd3;
  localparam logic [PC_W-1:0] StepEmit   = 3'd4;
  localparam logic [PC_W-1:0] StepDone   = 3'd5;
  localparam logic [PC_W-1:0] StepPload  = 3'd6;

  logic [PC_W-1:0] pc_q, pc_d;
  itad_uword_t     uword;
  logic            take;

  // control store
  always_comb begin
    unique case (pc_q)
      StepIdle:   uword = '{op: OP_ACCEPT, cond: C_NO_INPUT,  target: StepIdle};
      StepClear:  uword = '{op: OP_CLEAR,  cond: C_POW2,      target: StepPload};
      StepDabble: uword = '{op: OP_DABBLE, cond: C_CNT_MORE,  target: StepDabble};
      StepSkip:   uword = '{op: OP_SKIP,   cond: C_LEAD_ZERO, target: StepSkip};
      StepEmit:   uword = '{op: OP_EMIT,   cond: C_EMIT_MORE, target: StepEmit};
      StepDone:   uword = '{op: OP_NOP,    cond: C_ALWAYS,    target: StepIdle};
      StepPload:  uword = '{op: OP_PLOAD,  cond: C_ALWAYS,    target: StepSkip};
      default:    uword = '{op: OP_NOP,    cond: C_ALWAYS,    target: StepIdle};
    endcase
  end

  always_comb begin
    unique case (uword.cond)
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !cond_i.in_valid;
      C_POW2:      take = cond_i.is_pow2;
      C_CNT_MORE:  take = cond_i.cnt_more;
      C_LEAD_ZERO: take = cond_i.lead_zero;
      C_EMIT_MORE: take = cond_i.emit_more;
      default:     take = 1'b1;
    endcase
  end

  assign pc_d = take ? uword.target : pc_q + PC_W'(1);
  assign op_o = uword.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/integer_to_ascii_digits.sv -----
// Converts one unsigned number per input word to ASCII digits in octal, decimal or
// hexadecimal, most significant first, one digit per output word, no leading zeros,
// last_char set on the final digit. One number is handled at a time: the next word is
// taken only after the last digit of the previous number has been emitted. A decimal
// number goes through the shift-and-add-3 loop that moves one bit of the number into
// the BCD digit register per cycle; octal and hexadecimal digits are loaded as bit
// groups. Then a scan runs from the top digit position down through leading zeros,
// and then the digits are emitted.
// Bits of number above NUMBER_WIDTH are ignored; if MAX_DIGITS is too small for the
// value only its MAX_DIGITS least significant digits come out.
// depends on itad_pkg, itad_seq and integer_to_ascii_digits_defines.svh
`include "integer_to_ascii_digits_defines.svh"

module integer_to_ascii_digits #(
  parameter int NUMBER_WIDTH = 64,
  parameter int MAX_DIGITS   = 22
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itad_pkg::itad_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itad_pkg::itad_out_t out_word_o
);
  import itad_pkg::*;

  localparam int CntW = $clog2(NUMBER_WIDTH);
  localparam int PtrW = $clog2(MAX_DIGITS);
  localparam int ExtW = ((NUMBER_WIDTH > 4 * MAX_DIGITS) ? NUMBER_WIDTH : 4 * MAX_DIGITS) + 4;

  itad_op_e   op;
  itad_cond_t cond;

  logic [NUMBER_WIDTH-1:0] src_q, src_d;
  logic [3:0]              dig_q [MAX_DIGITS];
  logic [3:0]              dig_d [MAX_DIGITS];
  radix_e                  radix_q, radix_d;
  logic                    upper_q, upper_d;
  logic                    ovf_q, ovf_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [PtrW-1:0]         ptr_q, ptr_d;

  logic [3:0]      adj [MAX_DIGITS];
  logic [3:0]      dab_dig [MAX_DIGITS];
  logic            dab_carry;
  logic [ExtW-1:0] num_ext;
  logic [3:0]      p2_dig [MAX_DIGITS];
  logic            p2_ovf;
  logic [3:0]      cur_dig;
  logic            lead_zero;
  logic            ptr_zero;
  logic            out_hs;

  itad_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .op_o   (op)
  );

  // one shift-and-add-3 step, top carry dropped into the overflow flag
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
    dab_dig[0] = {adj[0][2:0], src_q[NUMBER_WIDTH-1]};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      dab_dig[i] = {adj[i][2:0], adj[i-1][3]};
    end
    dab_carry = adj[MAX_DIGITS-1][3];
  end

  // octal and hex digits are plain bit groups
  always_comb begin
    num_ext = ExtW'(src_q);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (radix_q == RADIX_HEX) begin
        p2_dig[i] = num_ext[4*i +: 4];
      end else begin
        p2_dig[i] = {1'b0, num_ext[3*i +: 3]};
      end
    end
    if (radix_q == RADIX_HEX) begin
      p2_ovf = |(num_ext >> (4 * MAX_DIGITS));
    end else begin
      p2_ovf = |(num_ext >> (3 * MAX_DIGITS));
    end
  end

  assign cur_dig   = dig_q[ptr_q];
  assign ptr_zero  = (ptr_q == '0);
  // when digits were dropped every stored position is printed
  assign lead_zero = !ovf_q && (cur_dig == 4'd0) && !ptr_zero;
  assign out_hs    = out_valid_o && !out_stall_i;

  assign cond.in_valid  = in_valid_i;
  assign cond.is_pow2   = (radix_q != RADIX_DEC);
  assign cond.cnt_more  = (cnt_q != '0);
  assign cond.lead_zero = lead_zero;
  assign cond.emit_more = !(out_hs && ptr_zero);

  assign in_stall_o  = (op != OP_ACCEPT);
  assign out_valid_o = (op == OP_EMIT);

  always_comb begin
    if (cur_dig < 4'd10) begin
      out_word_o.ascii_char = CHAR_ZERO + 7'(cur_dig);
    end else begin
      out_word_o.ascii_char = CHAR_ZERO + 7'(cur_dig) + LETTER_GAP
                            + (upper_q ? 7'd0 : LOWER_OFFSET);
    end
    out_word_o.last_char = ptr_zero;
  end

  always_comb begin
    src_d   = src_q;
    dig_d   = dig_q;
    radix_d = radix_q;
    upper_d = upper_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    unique case (op)
      OP_ACCEPT: begin
        if (in_valid_i) begin
          src_d   = in_word_i.number[NUMBER_WIDTH-1:0];
          upper_d = in_word_i.upper_case;
          if (in_word_i.radix_select[1]) begin
            radix_d = RADIX_HEX;
          end else if (in_word_i.radix_select == RADIX_DEC) begin
            radix_d = RADIX_DEC;
          end else begin
            radix_d = RADIX_OCT;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          dig_d[i] = 4'd0;
        end
        ovf_d = 1'b0;
        cnt_d = CntW'(NUMBER_WIDTH - 1);
        ptr_d = PtrW'(MAX_DIGITS - 1);
      end
      OP_DABBLE: begin
        dig_d = dab_dig;
        ovf_d = ovf_q | dab_carry;
        src_d = {src_q[NUMBER_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
      end
      OP_PLOAD: begin
        dig_d = p2_dig;
        ovf_d = p2_ovf;
      end
      OP_SKIP: begin
        if (lead_zero) begin
          ptr_d = ptr_q - PtrW'(1);
        end
      end
      OP_EMIT: begin
        if (out_hs && !ptr_zero) begin
          ptr_d = ptr_q - PtrW'(1);
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      ovf_q <= ovf_d;
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    dig_q   <= dig_d;
    radix_q <= radix_d;
    upper_q <= upper_d;
  end

  `ASSERT_IMPLIES(a_no_overlap, out_valid_o, in_stall_o, "output while taking input")
  `ASSERT_NEXT(a_last_ends, out_hs && out_word_o.last_char, !out_valid_o, "word after last")
  `ASSERT_NEXT(a_accept_quiet, in_valid_i && !in_stall_o, !out_valid_o && in_stall_o, "no work after accept")

endmodule

// ----- verif/tb_integer_to_ascii_digits.sv -----
// testbench for integer_to_ascii_digits: random and directed numbers in every radix,
// digits predicted in the bench and checked word by word under random stalls
// depends on itad_pkg and the integer_to_ascii_digits rtl
`timescale 1ns / 100ps

module tb_integer_to_ascii_digits;
  import itad_pkg::*;

  localparam int NUM_W         = 64;
  localparam int DIGITS_MAX    = 22;
  localparam int RANDOM_ITEMS  = 298;
  localparam int TAIL_ITEMS    = 50;
  localparam int HOLD_AFTER    = 40;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 120;
  localparam int CYCLE_LIMIT   = 600000;

  // code three is not in the enum, bit 1 alone selects hex
  localparam logic [1:0] RADIX_HEX_ALIAS = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  itad_in_t  in_word = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  itad_out_t out_word_o;

  itad_in_t  pending_numbers[$];
  itad_out_t expected_chars[$];
  itad_out_t want_char;

  int        gap_left;
  int        stall_left;
  logic      hold_done;
  logic      quiet_tail;
  int        numbers_taken;
  int        chars_checked;
  int        numbers_done;
  int        mismatch_count;
  int        cycle_count;
  int        oct_count;
  int        dec_count;
  int        hex_count;
  int        max_digits_seen;

  always #6 clk_i = ~clk_i;

  integer_to_ascii_digits #(
    .NUMBER_WIDTH (NUM_W),
    .MAX_DIGITS   (DIGITS_MAX)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at char %0d: %s got 0x%0h expected 0x%0h",
             chars_checked, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_ZERO + {3'b000, d} + LETTER_GAP + (upper ? 7'd0 : LOWER_OFFSET);
    end
    return c;
  endfunction

  // split the number into digits, least significant first, then queue them msd first
  task automatic predict_digits(input itad_in_t w);
    logic [63:0] rest;
    logic [63:0] base;
    logic [3:0]  digs[$];
    itad_out_t   c;
    int          k;
    rest = w.number;
    if (w.radix_select[1]) begin
      base = 64'd16;
      hex_count++;
    end else if (w.radix_select == RADIX_DEC) begin
      base = 64'd10;
      dec_count++;
    end else begin
      base = 64'd8;
      oct_count++;
    end
    do begin
      digs.push_back(4'(rest % base));
      rest = rest / base;
    end while (rest != 0 && digs.size() < DIGITS_MAX);
    if (digs.size() > max_digits_seen) max_digits_seen = digs.size();
    for (k = digs.size() - 1; k >= 0; k--) begin
      c.ascii_char = digit_char(digs[k], w.upper_case);
      c.last_char  = (k == 0);
      expected_chars.push_back(c);
    end
  endtask

  task automatic add_number(input logic [63:0] n, input logic [1:0] r, input logic up);
    itad_in_t w;
    w.number       = n;
    w.radix_select = r;
    w.upper_case   = up;
    pending_numbers.push_back(w);
  endtask

  // sender: presents queued numbers, random gaps until the tail of the run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid      <= 1'b0;
      in_word       <= '0;
      gap_left      <= 0;
      numbers_taken <= 0;
      quiet_tail    <= 1'b0;
    end else begin
      quiet_tail <= (pending_numbers.size() < TAIL_ITEMS);
      if (in_valid && !in_stall_o) begin
        predict_digits(in_word);
        numbers_taken <= numbers_taken + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_numbers.size() != 0) begin
          in_word  <= pending_numbers.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: short random bursts and one long hold so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && numbers_taken >= HOLD_AFTER) begin
      out_stall  <= 1'b1;
      stall_left <= LONG_HOLD;
      hold_done  <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // checker for each accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_word_o), 0);
      end else begin
        want_char = expected_chars.pop_front();
        if (out_word_o.ascii_char !== want_char.ascii_char)
          report_mismatch("ascii_char", 32'(out_word_o.ascii_char),
                          32'(want_char.ascii_char));
        if (out_word_o.last_char !== want_char.last_char)
          report_mismatch("last_char", 32'(out_word_o.last_char),
                          32'(want_char.last_char));
      end
      if (out_word_o.last_char === 1'b1) numbers_done++;
      chars_checked++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run
    logic [63:0] v;
    int          len;
    int          i;
    int          total;

    // zero, all ones, digit roll-overs, letters in both cases, radix code three
    add_number(64'd0, RADIX_OCT, 1'b0);
    add_number(64'd0, RADIX_DEC, 1'b1);
    add_number(64'd0, RADIX_HEX, 1'b1);
    add_number('1, RADIX_OCT, 1'b1);
    add_number('1, RADIX_DEC, 1'b0);
    add_number('1, RADIX_HEX, 1'b1);
    add_number('1, RADIX_HEX, 1'b0);
    add_number(64'd7, RADIX_OCT, 1'b0);
    add_number(64'd8, RADIX_OCT, 1'b1);
    add_number(64'd9, RADIX_DEC, 1'b0);
    add_number(64'd10, RADIX_DEC, 1'b1);
    add_number(64'd15, RADIX_HEX, 1'b0);
    add_number(64'd16, RADIX_HEX, 1'b1);
    add_number(64'd10000000000000000000, RADIX_DEC, 1'b0);
    add_number(64'd9999999999999999999, RADIX_DEC, 1'b1);
    add_number(64'h8000_0000_0000_0000, RADIX_OCT, 1'b0);
    add_number(64'h8000_0000_0000_0000, RADIX_HEX, 1'b0);
    add_number(64'hFEDC_BA98_7654_3210, RADIX_HEX, 1'b1);
    add_number(64'hFEDC_BA98_7654_3210, RADIX_HEX, 1'b0);
    add_number(64'h0000_0000_00AB_CDEF, RADIX_HEX_ALIAS, 1'b1);
    add_number(64'h0000_0000_00AB_CDEF, RADIX_HEX_ALIAS, 1'b0);
    add_number(64'd0, RADIX_HEX_ALIAS, 1'b1);
    add_number(64'h0123_4567_89AB_CDEF, RADIX_DEC, 1'b0);

    // random bit lengths so every digit count shows up
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      len = $urandom_range(0, NUM_W);
      v   = {$urandom, $urandom};
      if (len < NUM_W) v = v & ((64'd1 << len) - 64'd1);
      add_number(v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    total = pending_numbers.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (numbers_taken < total) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_chars.size() != 0)
      report_mismatch("words never produced", 0, expected_chars.size());

    $display("converted %0d numbers (octal %0d, decimal %0d, hex %0d), up to %0d digits",
             numbers_taken, oct_count, dec_count, hex_count, max_digits_seen);
    $display("checked %0d characters closing %0d numbers, %0d mismatches",
             chars_checked, numbers_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/itad_pkg.sv
hw/rtl/itad_seq.sv
hw/rtl/integer_to_ascii_digits.sv
verif/tb_integer_to_ascii_digits.sv
